>>> rtl/aopi_pkg.sv
// shared types, constants and arithmetic helpers for the odometry pose integrator
package aopi_pkg;

  localparam int unsigned WordW = 32;

  // func codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_BASE   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // config register indexes
  localparam logic [2:0] REG_V1OFF = 3'd0;
  localparam logic [2:0] REG_V2OFF = 3'd1;
  localparam logic [2:0] REG_H1OFF = 3'd2;
  localparam logic [2:0] REG_H2OFF = 3'd3;
  localparam logic [2:0] REG_PRES  = 3'd4;

  // heading source codes
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_IMU   = 2'd1;
  localparam logic [1:0] SRC_VERT  = 2'd2;
  localparam logic [1:0] SRC_HORIZ = 2'd3;

  localparam logic signed [31:0] HEADING_RST   = 32'sd102944;
  localparam logic signed [31:0] DEG_TO_RAD_Q32 = 32'sd74961321;
  localparam logic signed [31:0] RAD_TO_PHASE  = 32'sd683565276;
  localparam logic signed [33:0] CORDIC_GAIN   = 34'sd652032874;
  localparam int unsigned CordicSteps = 24;

  // cordic arctangent table, turn phase units
  function automatic logic [31:0] atan_phase(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'd536870912;   5'd1: r = 32'd316933406;
        5'd2: r = 32'd167458907;   5'd3: r = 32'd85004756;
        5'd4: r = 32'd42667331;    5'd5: r = 32'd21354465;
        5'd6: r = 32'd10679838;    5'd7: r = 32'd5340245;
        5'd8: r = 32'd2670163;     5'd9: r = 32'd1335087;
        5'd10: r = 32'd667544;     5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;     5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;      5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;      5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;       5'd19: r = 32'd1304;
        5'd20: r = 32'd652;        5'd21: r = 32'd326;
        5'd22: r = 32'd163;        5'd23: r = 32'd81;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

  // input word fields
  typedef struct packed {
    logic signed [31:0] set_theta;
    logic signed [31:0] set_y;
    logic signed [31:0] set_x;
    logic               imu_valid;
    logic signed [31:0] imu_rotation;
    logic signed [31:0] horiz_two_dist;
    logic signed [31:0] horiz_one_dist;
    logic signed [31:0] vert_two_dist;
    logic signed [31:0] vert_one_dist;
    logic [1:0]         func;
  } in_word_t;

  // datapath step commands
  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_SET, OP_BASE, OP_DELTA, OP_IMU_MUL, OP_IMU_RES,
    OP_DIV_START, OP_DIV_STEP, OP_DIV_END, OP_EST_MUL, OP_EST_ADD, OP_AVG,
    OP_SC_HALF, OP_SC_MID, OP_CORDIC, OP_SC_END, OP_CHORD_MUL, OP_CHORD_DIV,
    OP_ROT_MUL, OP_ROT_ADD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] step;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       need_div;
    logic       dth_zero;
    logic       div_done;
  } dp_stat_t;

endpackage

>>> rtl/aopi_datapath.sv
// datapath: baselines, pose, product registers, serial divider and cordic
module aopi_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  aopi_pkg::dp_cmd_t   cmd,
  output aopi_pkg::dp_stat_t  stat,
  input  aopi_pkg::in_word_t  in_word,
  input  logic signed [31:0]  off_r [4],
  input  logic [4:0]          pres_r,
  output logic signed [31:0]  pose_x,
  output logic signed [31:0]  pose_y,
  output logic signed [31:0]  pose_theta,
  output logic [31:0]         gen_count,
  output logic [1:0]          src_out
);

  aopi_pkg::in_word_t   item_r;
  logic signed [31:0]   last_r [4];
  logic signed [31:0]   last_imu_r, fx_r, fy_r, hd_r;
  logic [31:0]          gen_r;
  logic signed [31:0]   d_r [4];
  logic signed [31:0]   dth_r, fwd_r, rgt_r, cf_r, ly_r, lx_r, s_r, c_r;
  logic [1:0]           src_r;
  logic signed [63:0]   prod_r [4];
  // divider
  logic [63:0]          dq_r;
  logic [32:0]          drem_r;
  logic [31:0]          dden_r;
  logic                 dneg_r;
  logic [1:0]           dsel_r;
  logic [6:0]           dcnt_r;
  // cordic
  logic signed [33:0]   cx_r, cy_r, cz_r;
  logic                 flip_r, sc_mid_r;

  logic signed [31:0] diff_v, diff_h, num_v, num_h, di_w;
  logic               ok_v, ok_h, imu_use;

  assign imu_use = pres_r[4] && item_r.imu_valid;
  assign diff_v  = off_r[0] - off_r[1];
  assign diff_h  = off_r[2] - off_r[3];
  assign ok_v    = (pres_r[1:0] == 2'b11) && (diff_v != 0);
  assign ok_h    = (pres_r[3:2] == 2'b11) && (diff_h != 0);
  assign num_v   = d_r[0] - d_r[1];
  assign num_h   = d_r[3] - d_r[2];
  assign di_w    = item_r.imu_rotation - last_imu_r;

  assign stat.func     = item_r.func;
  assign stat.need_div = !imu_use && (ok_v || ok_h);
  assign stat.dth_zero = (dth_r == 0);
  assign stat.div_done = (dcnt_r == 7'd0);

  // q16 rounding of a product
  function automatic logic signed [31:0] qr(input logic signed [63:0] p);
    logic signed [63:0] t;
    begin
      t = p + 64'sd32768;
      return t[47:16];
    end
  endfunction

  logic signed [31:0] half_w, ang_w;
  logic signed [63:0] ph_p;
  logic [31:0]        ph_w;
  logic signed [31:0] est [4];
  logic signed [63:0] sum_f, sum_r;
  logic signed [33:0] ysh, xsh;
  logic signed [33:0] rx, ry;
  logic [32:0]        trial;

  assign half_w = dth_r >>> 1;
  assign ang_w  = (cmd.op == aopi_pkg::OP_SC_MID) ? hd_r + half_w : half_w;
  assign ph_p   = 64'(ang_w) * 64'(aopi_pkg::RAD_TO_PHASE) + 64'sd32768;
  assign ph_w   = ph_p[47:16];
  assign ysh    = cy_r >>> cmd.step[4:0];
  assign xsh    = cx_r >>> cmd.step[4:0];
  assign rx     = cx_r + 34'sd8192;
  assign ry     = cy_r + 34'sd8192;
  assign trial  = {drem_r[31:0], dq_r[63]} - {1'b0, dden_r};
  // per-wheel estimates wrap at 32 bits; prod_r holds off*dth products
  assign est[0] = d_r[0] - qr(prod_r[0]);
  assign est[1] = d_r[1] - qr(prod_r[1]);
  assign est[2] = d_r[2] + qr(prod_r[2]);
  assign est[3] = d_r[3] + qr(prod_r[3]);
  assign sum_f = (pres_r[0] ? 64'(est[0]) : 64'sd0)
               + (pres_r[1] ? 64'(est[1]) : 64'sd0);
  assign sum_r = (pres_r[2] ? 64'(est[2]) : 64'sd0)
               + (pres_r[3] ? 64'(est[3]) : 64'sd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) last_r[k] <= '0;
      last_imu_r <= '0;
      fx_r <= '0;
      fy_r <= '0;
      hd_r <= aopi_pkg::HEADING_RST;
      gen_r <= '0;
      src_r <= aopi_pkg::SRC_NONE;
      dcnt_r <= '0;
    end else begin
      unique case (cmd.op)
        aopi_pkg::OP_LOAD: begin
          item_r <= in_word;
          src_r <= aopi_pkg::SRC_NONE;
        end
        aopi_pkg::OP_SET: begin
          fx_r <= item_r.set_x;
          fy_r <= item_r.set_y;
          hd_r <= item_r.set_theta;
          gen_r <= gen_r + 32'd1;
        end
        aopi_pkg::OP_BASE: begin
          last_r[0] <= pres_r[0] ? item_r.vert_one_dist : '0;
          last_r[1] <= pres_r[1] ? item_r.vert_two_dist : '0;
          last_r[2] <= pres_r[2] ? item_r.horiz_one_dist : '0;
          last_r[3] <= pres_r[3] ? item_r.horiz_two_dist : '0;
          if (pres_r[4]) last_imu_r <= item_r.imu_valid ? item_r.imu_rotation : '0;
        end
        aopi_pkg::OP_DELTA: begin
          d_r[0] <= (pres_r[0] ? item_r.vert_one_dist : 32'sd0) - last_r[0];
          d_r[1] <= (pres_r[1] ? item_r.vert_two_dist : 32'sd0) - last_r[1];
          d_r[2] <= (pres_r[2] ? item_r.horiz_one_dist : 32'sd0) - last_r[2];
          d_r[3] <= (pres_r[3] ? item_r.horiz_two_dist : 32'sd0) - last_r[3];
          last_r[0] <= pres_r[0] ? item_r.vert_one_dist : '0;
          last_r[1] <= pres_r[1] ? item_r.vert_two_dist : '0;
          last_r[2] <= pres_r[2] ? item_r.horiz_one_dist : '0;
          last_r[3] <= pres_r[3] ? item_r.horiz_two_dist : '0;
          dth_r <= '0;
        end
        aopi_pkg::OP_IMU_MUL: begin
          prod_r[0] <= 64'(di_w) * 64'(aopi_pkg::DEG_TO_RAD_Q32);
        end
        aopi_pkg::OP_IMU_RES: begin
          if (imu_use) begin
            dth_r <= -32'(64'(prod_r[0] + 64'sh80000000) >>> 32);
            last_imu_r <= item_r.imu_rotation;
            src_r <= aopi_pkg::SRC_IMU;
          end
        end
        aopi_pkg::OP_DIV_START: begin
          // heading quotient (num << 16) / diff
          logic signed [31:0] nn, dd;
          nn = ok_v ? num_v : num_h;
          dd = ok_v ? diff_v : diff_h;
          src_r <= ok_v ? aopi_pkg::SRC_VERT : aopi_pkg::SRC_HORIZ;
          dq_r <= (nn[31] ? 64'(-64'(nn)) : 64'(nn)) << 16;
          dden_r <= dd[31] ? -dd : dd;
          dneg_r <= nn[31] ^ dd[31];
          drem_r <= '0;
          dcnt_r <= 7'd64;
          dsel_r <= 2'd0;
        end
        aopi_pkg::OP_CHORD_DIV: begin
          // chord numerator arc*cf over dth; sel 1 = ly, 2 = lx
          logic signed [63:0] nn;
          nn = (cmd.step[0] == 1'b0) ? prod_r[0] : prod_r[1];
          dq_r <= nn[63] ? -nn : nn;
          dden_r <= dth_r[31] ? -dth_r : dth_r;
          dneg_r <= nn[63] ^ dth_r[31];
          drem_r <= '0;
          dcnt_r <= 7'd64;
          dsel_r <= (cmd.step[0] == 1'b0) ? 2'd1 : 2'd2;
        end
        aopi_pkg::OP_DIV_STEP: begin
          if (dcnt_r != 0) begin
            dcnt_r <= dcnt_r - 7'd1;
            if (!trial[32]) begin
              drem_r <= trial;
              dq_r <= {dq_r[62:0], 1'b1};
            end else begin
              drem_r <= {drem_r[31:0], dq_r[63]};
              dq_r <= {dq_r[62:0], 1'b0};
            end
          end
        end
        aopi_pkg::OP_DIV_END: begin
          logic [31:0] q;
          q = dneg_r ? -dq_r[31:0] : dq_r[31:0];
          unique case (dsel_r)
            2'd0: dth_r <= q;
            2'd1: ly_r <= q;
            default: lx_r <= q;
          endcase
        end
        aopi_pkg::OP_EST_MUL: begin
          for (int k = 0; k < 4; k++) prod_r[k] <= 64'(off_r[k]) * 64'(dth_r);
        end
        aopi_pkg::OP_AVG: begin
          fwd_r <= (pres_r[1:0] == 2'b11) ? 32'(sum_f >>> 1) : sum_f[31:0];
          rgt_r <= (pres_r[3:2] == 2'b11) ? 32'(sum_r >>> 1) : sum_r[31:0];
        end
        aopi_pkg::OP_SC_HALF, aopi_pkg::OP_SC_MID: begin
          logic [31:0] p;
          logic        fl;
          fl = (ph_w[31:30] == 2'b01) || (ph_w[31:30] == 2'b10);
          p = fl ? ph_w - 32'h80000000 : ph_w;
          flip_r <= fl;
          sc_mid_r <= (cmd.op == aopi_pkg::OP_SC_MID);
          cx_r <= aopi_pkg::CORDIC_GAIN;
          cy_r <= '0;
          cz_r <= 34'(signed'(p));
        end
        aopi_pkg::OP_CORDIC: begin
          if (!cz_r[33]) begin
            cx_r <= cx_r - ysh;
            cy_r <= cy_r + xsh;
            cz_r <= cz_r - 34'(aopi_pkg::atan_phase(cmd.step[4:0]));
          end else begin
            cx_r <= cx_r + ysh;
            cy_r <= cy_r - xsh;
            cz_r <= cz_r + 34'(aopi_pkg::atan_phase(cmd.step[4:0]));
          end
        end
        aopi_pkg::OP_SC_END: begin
          logic signed [31:0] cc, ss;
          cc = flip_r ? -32'(rx >>> 14) : 32'(rx >>> 14);
          ss = flip_r ? -32'(ry >>> 14) : 32'(ry >>> 14);
          if (sc_mid_r) begin
            c_r <= cc;
            s_r <= ss;
          end else begin
            cf_r <= ss <<< 1;
            ly_r <= fwd_r;
            lx_r <= rgt_r;
          end
        end
        aopi_pkg::OP_CHORD_MUL: begin
          prod_r[0] <= 64'(fwd_r) * 64'(cf_r);
          prod_r[1] <= 64'(rgt_r) * 64'(cf_r);
        end
        aopi_pkg::OP_ROT_MUL: begin
          prod_r[0] <= 64'(ly_r) * 64'(c_r);
          prod_r[1] <= 64'(lx_r) * 64'(s_r);
          prod_r[2] <= 64'(ly_r) * 64'(s_r);
          prod_r[3] <= 64'(lx_r) * 64'(c_r);
        end
        aopi_pkg::OP_ROT_ADD: begin
          fx_r <= fx_r + qr(prod_r[0]) + qr(prod_r[1]);
          fy_r <= fy_r + qr(prod_r[2]) - qr(prod_r[3]);
          hd_r <= hd_r + dth_r;
        end
        default: ;
      endcase
    end
  end

  assign pose_x     = fx_r;
  assign pose_y     = fy_r;
  assign pose_theta = hd_r;
  assign gen_count  = gen_r;
  assign src_out    = src_r;

endmodule

>>> rtl/aopi_ctrl.sv
// controller: sequences the datapath over one item and runs the handshakes
module aopi_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire,
  output logic               busy,
  output logic               done,
  output aopi_pkg::dp_cmd_t  cmd,
  input  aopi_pkg::dp_stat_t stat
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_DISP  = 14'b00000000000010,
    S_DELTA = 14'b00000000000100,
    S_IMUM  = 14'b00000000001000,
    S_IMUR  = 14'b00000000010000,
    S_DIV   = 14'b00000000100000,
    S_EST   = 14'b00000001000000,
    S_AVG   = 14'b00000010000000,
    S_SCH   = 14'b00000100000000,
    S_CRD   = 14'b00001000000000,
    S_CHORD = 14'b00010000000000,
    S_SCM   = 14'b00100000000000,
    S_ROT   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t     st_r, st_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       mid_r, mid_nxt;
  logic [2:0] ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      mid_r <= 1'b0;
      ph_r <= '0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      mid_r <= mid_nxt;
      ph_r <= ph_nxt;
    end
  end

  // next state and command
  always_comb begin
    st_nxt = st_r;
    cnt_nxt = cnt_r;
    mid_nxt = mid_r;
    ph_nxt = ph_r;
    cmd.op = aopi_pkg::OP_NONE;
    cmd.step = cnt_r;
    busy = 1'b1;
    done = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.op = aopi_pkg::OP_LOAD;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.func == aopi_pkg::FUNC_TICK) st_nxt = S_DELTA;
        else if (stat.func == aopi_pkg::FUNC_SET) begin
          cmd.op = aopi_pkg::OP_SET;
          st_nxt = S_DONE;
        end else if (stat.func == aopi_pkg::FUNC_BASE) begin
          cmd.op = aopi_pkg::OP_BASE;
          st_nxt = S_DONE;
        end else st_nxt = S_DONE;
      end
      S_DELTA: begin
        cmd.op = aopi_pkg::OP_DELTA;
        st_nxt = S_IMUM;
      end
      S_IMUM: begin
        cmd.op = aopi_pkg::OP_IMU_MUL;
        st_nxt = S_IMUR;
      end
      S_IMUR: begin
        cmd.op = aopi_pkg::OP_IMU_RES;
        if (stat.need_div) begin
          ph_nxt = 3'd0;
          st_nxt = S_DIV;
        end else st_nxt = S_EST;
      end
      // ph 0 start, 1 steps, 2 finish
      S_DIV: begin
        unique case (ph_r)
          3'd0: begin
            cmd.op = aopi_pkg::OP_DIV_START;
            ph_nxt = 3'd1;
          end
          3'd1: begin
            cmd.op = aopi_pkg::OP_DIV_STEP;
            if (stat.div_done) ph_nxt = 3'd2;
          end
          default: begin
            cmd.op = aopi_pkg::OP_DIV_END;
            st_nxt = S_EST;
          end
        endcase
      end
      S_EST: begin
        cmd.op = aopi_pkg::OP_EST_MUL;
        st_nxt = S_AVG;
      end
      S_AVG: begin
        cmd.op = aopi_pkg::OP_AVG;
        st_nxt = S_SCH;
      end
      S_SCH: begin
        cmd.op = aopi_pkg::OP_SC_HALF;
        cnt_nxt = '0;
        mid_nxt = 1'b0;
        st_nxt = S_CRD;
      end
      S_CRD: begin
        if (cnt_r < 6'(aopi_pkg::CordicSteps)) begin
          cmd.op = aopi_pkg::OP_CORDIC;
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          cmd.op = aopi_pkg::OP_SC_END;
          ph_nxt = 3'd0;
          priority if (mid_r) st_nxt = S_ROT;
          else if (stat.dth_zero) st_nxt = S_SCM;
          else st_nxt = S_CHORD;
        end
      end
      // chord: mul, then two divides (forward, right)
      S_CHORD: begin
        unique case (ph_r)
          3'd0: begin
            cmd.op = aopi_pkg::OP_CHORD_MUL;
            ph_nxt = 3'd1;
          end
          3'd1, 3'd4: begin
            cmd.op = aopi_pkg::OP_CHORD_DIV;
            cmd.step = (ph_r == 3'd1) ? 6'd0 : 6'd1;
            ph_nxt = ph_r + 3'd1;
          end
          3'd2, 3'd5: begin
            cmd.op = aopi_pkg::OP_DIV_STEP;
            if (stat.div_done) ph_nxt = ph_r + 3'd1;
          end
          3'd3: begin
            cmd.op = aopi_pkg::OP_DIV_END;
            ph_nxt = 3'd4;
          end
          default: begin
            cmd.op = aopi_pkg::OP_DIV_END;
            st_nxt = S_SCM;
          end
        endcase
      end
      S_SCM: begin
        cmd.op = aopi_pkg::OP_SC_MID;
        cnt_nxt = '0;
        mid_nxt = 1'b1;
        st_nxt = S_CRD;
      end
      S_ROT: begin
        if (ph_r == 3'd0) begin
          cmd.op = aopi_pkg::OP_ROT_MUL;
          ph_nxt = 3'd1;
        end else begin
          cmd.op = aopi_pkg::OP_ROT_ADD;
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        done = 1'b1;
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule

>>> rtl/arc_odometry_pose_integrator_core.sv
// top level: arc-based wheel odometry pose integrator
// a tick runs two 24-step cordic passes and, where needed, a heading divide and two chord
//   divides of 64 steps; set pose, baseline and unused func words skip all of them
// one word at a time: in_tready stays low while busy or while a result waits, and the next
//   word can be taken in the cycle after the result is accepted
// reset: synchronous active-low rst_n clears config, baselines, pose, counter, heading to pi/2
module arc_odometry_pose_integrator_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // func, vert_one_dist, vert_two_dist, horiz_one_dist, horiz_two_dist,
  // imu_rotation, imu_valid, set_x, set_y, set_theta (lowest first)
  input  logic [263:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // pose_x, pose_y, pose_theta, reset_count, heading_source (lowest first)
  output logic [135:0]  out_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  logic signed [31:0]  off_r [4];
  logic [4:0]          pres_r;
  aopi_pkg::dp_cmd_t   cmd;
  aopi_pkg::dp_stat_t  stat;
  aopi_pkg::in_word_t  in_word;
  logic                busy, done, in_fire;
  logic signed [31:0]  px, py, pt;
  logic [31:0]         gc;
  logic [1:0]          src;
  logic [135:0]        out_r;
  logic                ov_r;

  assign in_word   = in_tdata[258:0];
  assign in_tready = !busy && !ov_r;
  assign in_fire   = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) off_r[k] <= '0;
      pres_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aopi_pkg::REG_V1OFF: off_r[0] <= cfg_data;
        aopi_pkg::REG_V2OFF: off_r[1] <= cfg_data;
        aopi_pkg::REG_H1OFF: off_r[2] <= cfg_data;
        aopi_pkg::REG_H2OFF: off_r[3] <= cfg_data;
        aopi_pkg::REG_PRES:  pres_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  aopi_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .busy, .done, .cmd, .stat
  );

  aopi_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .in_word, .off_r, .pres_r,
    .pose_x(px), .pose_y(py), .pose_theta(pt), .gen_count(gc), .src_out(src)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (done) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) out_r <= {6'd0, src, gc, pt, py, px};
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

endmodule
